/* design/udc_pkg.sv */
// Shared types, constants and a helper function of the UART baud divisor calculator.
// Depends on nothing; every other design file imports it.
package udc_pkg;

  localparam int unsigned NUM_RATES = 10;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned ClkW      = 25;
  localparam int unsigned RateW     = 18;
  localparam int unsigned BoundW    = 25;
  localparam int unsigned DivW      = ClkW + 4;
  localparam int unsigned DivCntW   = 5;
  localparam int unsigned StepW     = 4;

  localparam logic [IdxW-1:0]    RateTop     = IdxW'(NUM_RATES - 1);
  localparam logic [DivCntW-1:0] DivLastStep = DivCntW'(DivW - 1);

  localparam logic [6:0] MinRatio   = 7'd48;
  localparam logic [6:0] RatioPlain = 7'd34;
  localparam logic [6:0] RatioOdd   = 7'd69;

  localparam logic [15:0] PrescOdd   = 16'd4;
  localparam logic [7:0]  ModOdd     = 8'h3A | 8'h01;
  localparam logic [15:0] PrescPlain = 16'd2;
  localparam logic [7:0]  ModPlain   = 8'h26 | 8'h01;

  localparam logic [ClkW-1:0] LowClkReset  = 25'd32768;
  localparam logic [ClkW-1:0] HighClkReset = 25'd16000000;

  // Configuration register indexes.
  localparam logic CfgLowClk  = 1'b0;
  localparam logic CfgHighClk = 1'b1;

  // Microcode step addresses.
  localparam logic [StepW-1:0] StWait    = 4'd0;
  localparam logic [StepW-1:0] StTstLow  = 4'd1;
  localparam logic [StepW-1:0] StTstHigh = 4'd2;
  localparam logic [StepW-1:0] StTst34   = 4'd3;
  localparam logic [StepW-1:0] StIdxZero = 4'd4;
  localparam logic [StepW-1:0] StDec     = 4'd5;
  localparam logic [StepW-1:0] StErr     = 4'd6;
  localparam logic [StepW-1:0] StTst69   = 4'd7;
  localparam logic [StepW-1:0] StDivInit = 4'd8;
  localparam logic [StepW-1:0] StDivStep = 4'd9;
  localparam logic [StepW-1:0] StResult  = 4'd10;
  localparam logic [StepW-1:0] StRestart = 4'd11;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_TST_LOW,
    OP_TST_HIGH,
    OP_TST_34,
    OP_TST_69,
    OP_DEC,
    OP_ERR,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_RESULT
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOT_FIRE,
    C_HIT,
    C_IDX_ZERO,
    C_DIV_MORE,
    C_OUT_BLOCKED
  } cond_e;

  typedef enum logic [2:0] {
    MODE_LOW,
    MODE_HIGH,
    MODE_ODD,
    MODE_PLAIN,
    MODE_ERR
  } mode_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [StepW-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic hit;
    logic idx_zero;
    logic div_more;
    logic out_blocked;
  } dp_status_t;

  function automatic logic [RateW-1:0] rate_of(input logic [IdxW-1:0] idx);
    logic [RateW-1:0] r;
    unique case (idx)
      4'd0:    r = 18'd300;
      4'd1:    r = 18'd1200;
      4'd2:    r = 18'd2400;
      4'd3:    r = 18'd4800;
      4'd4:    r = 18'd9600;
      4'd5:    r = 18'd19200;
      4'd6:    r = 18'd38400;
      4'd7:    r = 18'd57600;
      4'd8:    r = 18'd115200;
      4'd9:    r = 18'd230400;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* design/udc_req_if.sv */
// Request channel of the baud divisor calculator: valid, ready and the rate index.
// Depends on udc_pkg.
interface udc_req_if import udc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] requested_rate_index;

  modport source (output valid, output requested_rate_index, input ready);
  modport sink   (input valid, input requested_rate_index, output ready);
endinterface

/* design/udc_rsp_if.sv */
// Result channel of the baud divisor calculator: valid, ready and the divisor settings.
// Depends on udc_pkg.
interface udc_rsp_if import udc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] achieved_rate_index;
  logic [15:0]     prescaler;
  logic [7:0]      modulation;
  logic            clock_select;
  logic            rate_error;

  modport source (output valid, output achieved_rate_index, output prescaler,
                  output modulation, output clock_select, output rate_error, input ready);
  modport sink   (input valid, input achieved_rate_index, input prescaler,
                  input modulation, input clock_select, input rate_error, output ready);
endinterface

/* design/uart_baud_divisor_calculator_top.sv */
// Channel  | Dir | Payload                                        | Handshake
// req_i    | in  | requested_rate_index                           | valid/ready
// rsp_o    | out | achieved_rate_index, prescaler, modulation,    | valid/ready
//          |     | clock_select, rate_error                       |
// cfg      | in  | cfg_idx_i, cfg_wdata_i                         | cfg_we_i, no stall
//
// Before the next request can be taken, the sequencer runs: the wait step, five
// microcode steps for each rate lowered past (up to nine), up to three tests on the rate
// that fits, a set-up step and 29 one-bit divider steps where a division is needed, and
// two steps to hand the result over. No fit at index 0 costs five steps there.
// A new request is taken only at the wait step. The result register frees the sequencer
// while a result waits on rsp_o.ready; the hand-over step stalls only while an earlier
// result still waits. Reset clears the step counter and the result valid and loads the
// clock defaults.
//
// Top level: step counter and jump logic around the control store and datapath.
// Depends on udc_pkg, udc_req_if, udc_rsp_if, udc_ucode_rom and udc_datapath.
module uart_baud_divisor_calculator_top import udc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [ClkW-1:0] cfg_wdata_i,
  udc_req_if.sink         req_i,
  udc_rsp_if.source       rsp_o
);

  logic [StepW-1:0] step_q, step_d;
  ctrl_word_t       word;
  dp_status_t       status;
  logic             in_fire;
  logic             take_jump;

  assign req_i.ready = (step_q == StWait);
  assign in_fire     = req_i.valid && req_i.ready;

  udc_ucode_rom u_rom (
    .step_i (step_q),
    .word_o (word)
  );

  udc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (word.op),
    .in_fire_i   (in_fire),
    .in_idx_i    (req_i.requested_rate_index),
    .out_ready_i (rsp_o.ready),
    .status_o    (status),
    .out_valid_o (rsp_o.valid),
    .out_idx_o   (rsp_o.achieved_rate_index),
    .out_presc_o (rsp_o.prescaler),
    .out_mod_o   (rsp_o.modulation),
    .out_sel_o   (rsp_o.clock_select),
    .out_err_o   (rsp_o.rate_error)
  );

  always_comb begin
    unique case (word.cond)
      C_NEXT:        take_jump = 1'b0;
      C_ALWAYS:      take_jump = 1'b1;
      C_NOT_FIRE:    take_jump = !in_fire;
      C_HIT:         take_jump = status.hit;
      C_IDX_ZERO:    take_jump = status.idx_zero;
      C_DIV_MORE:    take_jump = status.div_more;
      C_OUT_BLOCKED: take_jump = status.out_blocked;
      default:       take_jump = 1'b1;
    endcase
  end

  assign step_d = take_jump ? word.target : step_q + 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StWait;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

/* design/udc_ucode_rom.sv */
// Read-only control store of the calculator sequencer: one control word per step.
// Depends on udc_pkg.
module udc_ucode_rom import udc_pkg::*; (
  input  logic [StepW-1:0] step_i,
  output ctrl_word_t       word_o
);

  always_comb begin
    unique case (step_i)
      StWait:    word_o = '{op: OP_LOAD,     cond: C_NOT_FIRE,    target: StWait};
      StTstLow:  word_o = '{op: OP_TST_LOW,  cond: C_HIT,         target: StDivInit};
      StTstHigh: word_o = '{op: OP_TST_HIGH, cond: C_HIT,         target: StTst69};
      StTst34:   word_o = '{op: OP_TST_34,   cond: C_HIT,         target: StResult};
      StIdxZero: word_o = '{op: OP_NOP,      cond: C_IDX_ZERO,    target: StErr};
      StDec:     word_o = '{op: OP_DEC,      cond: C_ALWAYS,      target: StTstLow};
      StErr:     word_o = '{op: OP_ERR,      cond: C_ALWAYS,      target: StResult};
      StTst69:   word_o = '{op: OP_TST_69,   cond: C_HIT,         target: StResult};
      StDivInit: word_o = '{op: OP_DIV_INIT, cond: C_NEXT,        target: StWait};
      StDivStep: word_o = '{op: OP_DIV_STEP, cond: C_DIV_MORE,    target: StDivStep};
      StResult:  word_o = '{op: OP_RESULT,   cond: C_OUT_BLOCKED, target: StResult};
      StRestart: word_o = '{op: OP_NOP,      cond: C_ALWAYS,      target: StWait};
      default:   word_o = '{op: OP_NOP,      cond: C_ALWAYS,      target: StWait};
    endcase
  end

endmodule

/* design/udc_datapath.sv */
// Datapath of the calculator: clock registers, ratio compare, serial divider, result register.
// Depends on udc_pkg; driven by the control word from udc_ucode_rom.
module udc_datapath import udc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [ClkW-1:0] cfg_wdata_i,
  input  op_e             op_i,
  input  logic            in_fire_i,
  input  logic [IdxW-1:0] in_idx_i,
  input  logic            out_ready_i,
  output dp_status_t      status_o,
  output logic            out_valid_o,
  output logic [IdxW-1:0] out_idx_o,
  output logic [15:0]     out_presc_o,
  output logic [7:0]      out_mod_o,
  output logic            out_sel_o,
  output logic            out_err_o
);

  logic [ClkW-1:0]    low_clk_q, high_clk_q;
  logic [IdxW-1:0]    idx_q, idx_d;
  mode_e              mode_q, mode_d;
  logic [DivW-1:0]    div_q, div_d;
  logic [RateW-1:0]   rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [IdxW-1:0]    out_idx_q, out_idx_d;
  logic [15:0]        out_presc_q, out_presc_d;
  logic [7:0]         out_mod_q, out_mod_d;
  logic               out_sel_q, out_sel_d;
  logic               out_err_q, out_err_d;

  logic [RateW-1:0]  rate;
  logic [6:0]        ratio_k;
  logic [BoundW-1:0] lo_bound, hi_bound;
  logic [ClkW-1:0]   cmp_clk;
  logic              band;
  logic              hit;
  logic [RateW+1:0]  trial;
  logic [4:0]        hi_stage;
  logic              out_blocked;

  // One shared compare: clock >= k * rate, and for the exact-ratio tests also
  // clock < (k + 1) * rate, which is the same as clock / rate == k.
  assign rate    = rate_of(idx_q);
  assign cmp_clk = (op_i == OP_TST_LOW) ? low_clk_q : high_clk_q;
  assign band    = (op_i == OP_TST_34) || (op_i == OP_TST_69);

  always_comb begin
    unique case (op_i)
      OP_TST_34: ratio_k = RatioPlain;
      OP_TST_69: ratio_k = RatioOdd;
      default:   ratio_k = MinRatio;
    endcase
  end

  assign lo_bound = BoundW'(rate) * BoundW'(ratio_k);
  assign hi_bound = lo_bound + BoundW'(rate);
  assign hit      = (cmp_clk >= lo_bound) && (!band || (cmp_clk < hi_bound));

  assign trial       = {1'b0, rem_q, div_q[DivW-1]} - {2'b00, rate};
  assign out_blocked = out_valid_q && !out_ready_i;
  assign hi_stage    = div_q[7:3] + 5'd1;

  assign status_o = '{hit:         hit,
                      idx_zero:    (idx_q == '0),
                      div_more:    (cnt_q != DivLastStep),
                      out_blocked: out_blocked};

  always_comb begin
    idx_d       = idx_q;
    mode_d      = mode_q;
    div_d       = div_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_idx_d   = out_idx_q;
    out_presc_d = out_presc_q;
    out_mod_d   = out_mod_q;
    out_sel_d   = out_sel_q;
    out_err_d   = out_err_q;

    unique case (op_i)
      OP_LOAD: begin
        if (in_fire_i) begin
          idx_d  = (in_idx_i > RateTop) ? RateTop : in_idx_i;
          mode_d = MODE_ERR;
        end
      end
      OP_TST_LOW:  if (hit) mode_d = MODE_LOW;
      OP_TST_HIGH: if (hit) mode_d = MODE_HIGH;
      OP_TST_34:   if (hit) mode_d = MODE_PLAIN;
      OP_TST_69:   if (hit) mode_d = MODE_ODD;
      OP_DEC:      idx_d = idx_q - 4'd1;
      OP_ERR:      mode_d = MODE_ERR;
      OP_DIV_INIT: begin
        div_d = (mode_q == MODE_LOW) ? {low_clk_q, 4'b0000} : {high_clk_q, 4'b0000};
        rem_d = '0;
        cnt_d = '0;
      end
      OP_DIV_STEP: begin
        // Restoring division, one quotient bit per cycle, MSB first.
        if (!trial[RateW+1]) begin
          rem_d = trial[RateW-1:0];
          div_d = {div_q[DivW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[RateW-2:0], div_q[DivW-1]};
          div_d = {div_q[DivW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
      end
      OP_RESULT: begin
        if (!out_blocked) begin
          out_valid_d = 1'b1;
          out_idx_d   = idx_q;
          out_err_d   = 1'b0;
          out_sel_d   = 1'b1;
          unique case (mode_q)
            MODE_LOW: begin
              out_sel_d   = 1'b0;
              out_presc_d = div_q[19:4];
              out_mod_d   = {4'b0000, (div_q[3:0] + 4'd1) & 4'hE};
            end
            MODE_HIGH: begin
              out_presc_d = div_q[23:8];
              out_mod_d   = {hi_stage[4:1], 4'b0001};
            end
            MODE_ODD: begin
              out_presc_d = PrescOdd;
              out_mod_d   = ModOdd;
            end
            MODE_PLAIN: begin
              out_presc_d = PrescPlain;
              out_mod_d   = ModPlain;
            end
            default: begin
              out_sel_d   = 1'b0;
              out_err_d   = 1'b1;
              out_idx_d   = '0;
              out_presc_d = '0;
              out_mod_d   = '0;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_clk_q   <= LowClkReset;
      high_clk_q  <= HighClkReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CfgLowClk))  low_clk_q  <= cfg_wdata_i;
      if (cfg_we_i && (cfg_idx_i == CfgHighClk)) high_clk_q <= cfg_wdata_i;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    mode_q      <= mode_d;
    div_q       <= div_d;
    rem_q       <= rem_d;
    cnt_q       <= cnt_d;
    out_idx_q   <= out_idx_d;
    out_presc_q <= out_presc_d;
    out_mod_q   <= out_mod_d;
    out_sel_q   <= out_sel_d;
    out_err_q   <= out_err_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_idx_o   = out_idx_q;
  assign out_presc_o = out_presc_q;
  assign out_mod_o   = out_mod_q;
  assign out_sel_o   = out_sel_q;
  assign out_err_o   = out_err_q;

endmodule
